// ===== sv/tvrp_pkg.sv =====
// ----------------------------------------------------------------------------
// Tile video register port package
// Shared constants, the access and register codes, and the map from the
// 14-bit video space onto the combined video RAM.
// ----------------------------------------------------------------------------
`default_nettype none

package tvrp_pkg;

	localparam int PATTERN_BANK_BYTES = 4096;
	localparam int NAMETABLE_BYTES    = 1024;
	localparam int SPRITE_MEM_BYTES   = 256;
	localparam int PALETTE_BYTES      = 32;

	// The video RAM holds pattern memory, then the nametables, then the palette.
	localparam int VID_NT_BASE  = 2 * PATTERN_BANK_BYTES;
	localparam int VID_PAL_BASE = VID_NT_BASE + 2 * NAMETABLE_BYTES;
	localparam int VID_DEPTH    = VID_PAL_BASE + PALETTE_BYTES;
	localparam int VID_AW       = $clog2(VID_DEPTH);
	localparam int SPR_AW       = $clog2(SPRITE_MEM_BYTES);

	localparam logic [13:0] PALETTE_START = 14'h3F00;
	localparam logic [13:0] NT_END        = 14'h3EFF;
	localparam logic [13:0] PATTERN_END   = 14'h1FFF;

	// Access codes.
	localparam logic [2:0] OP_READ   = 3'd0;
	localparam logic [2:0] OP_WRITE  = 3'd1;
	localparam logic [2:0] OP_PEEK   = 3'd2;
	localparam logic [2:0] OP_VBLANK = 3'd3;
	localparam logic [2:0] OP_FRAME  = 3'd4;

	// Register numbers.
	localparam logic [2:0] REG_CONTROL  = 3'd0;
	localparam logic [2:0] REG_MASK     = 3'd1;
	localparam logic [2:0] REG_STATUS   = 3'd2;
	localparam logic [2:0] REG_OAM_ADDR = 3'd3;
	localparam logic [2:0] REG_OAM_DATA = 3'd4;
	localparam logic [2:0] REG_SCROLL   = 3'd5;
	localparam logic [2:0] REG_ADDR     = 3'd6;
	localparam logic [2:0] REG_DATA     = 3'd7;

	// Nametable mirroring modes.
	localparam logic [1:0] MIRROR_VERT  = 2'd0;
	localparam logic [1:0] MIRROR_HORIZ = 2'd1;

	typedef struct packed {
		logic              hit;  // entry exists (an unmapped nametable has none)
		logic              pal;  // palette entry
		logic [VID_AW-1:0] idx;
	} vid_map_t;

	function automatic vid_map_t vid_map(input logic [13:0] a, input logic [1:0] mode);
		vid_map_t         m;
		logic             tsel;
		logic [4:0]       p;
		logic [VID_AW:0]  nt_idx;
		m.hit  = 1'b1;
		m.pal  = 1'b0;
		m.idx  = '0;
		tsel   = 1'b0;
		p      = a[4:0];
		nt_idx = '0;
		if (a <= PATTERN_END) begin
			m.idx = VID_AW'(a[12:0]);
		end else if (a <= NT_END) begin
			case (mode)
				MIRROR_VERT: tsel = a[10];
				MIRROR_HORIZ: tsel = a[11];
				default: m.hit = 1'b0;
			endcase
			nt_idx = (VID_AW+1)'(VID_NT_BASE) + (VID_AW+1)'({tsel, a[9:0]});
			m.idx  = nt_idx[VID_AW-1:0];
		end else begin
			// Entries 0x10, 0x14, 0x18 and 0x1C share storage with 0x00..0x0C.
			if (p[4] && (p[1:0] == 2'b00)) begin
				p[4] = 1'b0;
			end
			m.pal = 1'b1;
			m.idx = VID_AW'(VID_PAL_BASE) | VID_AW'(p);
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== sv/tvrp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tvrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== sv/tile_video_register_port_core.sv =====
// ----------------------------------------------------------------------------
// Tile video register port core
// CPU-side register file of a tile video processor with its video memories.
// ----------------------------------------------------------------------------
// Usage:
// An access is taken at a rising edge with start high and busy low. The
// access fields are operation, reg_index and write_data. Each access gives
// exactly one result: done is high for one cycle with read_data and
// nmi_raise. The receiver cannot stall; the result is simply presented.
// Stages: an accepted access issues its register update and memory access in
// the accept stage, and the result stage takes the registered read data of the
// video and sprite RAMs and forms the result. busy is high while an access is
// between the stages, so the next access is taken once it reaches the result stage.
// Mirroring is written on the cfg channel (cfg_valid, cfg_ready, cfg_data);
// cfg_ready is always high, and writes belong in idle time.
// Reset clears all registers; RAM contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_video_register_port_core
	import tvrp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [2:0] operation,
	input  wire logic [2:0] reg_index,
	input  wire logic [7:0] write_data,
	output logic            done,
	output logic      [7:0] read_data,
	output logic            nmi_raise,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_data
);

	localparam logic [1:0] SRC_REG = 2'd0;
	localparam logic [1:0] SRC_SPR = 2'd1;
	localparam logic [1:0] SRC_VID = 2'd2;

	logic [1:0]  mirror_q;
	logic [7:0]  control_q;
	logic [7:0]  mask_q;
	logic [2:0]  status_q;
	logic [14:0] temp_addr_q;
	logic [15:0] vram_addr_q;
	logic [2:0]  fine_x_q;
	logic        toggle_q;
	logic [7:0]  rbuf_q;
	logic [7:0]  oam_addr_q;

	logic        pend_s1;
	logic [1:0]  src_s1;
	logic [7:0]  rd_s1;
	logic        nmi_s1;
	logic        pal_s1;
	logic        ntz_s1;

	logic        done_q;
	logic [7:0]  rdata_q;
	logic        nmi_q;

	logic        acc;
	logic        is_rd;
	logic        is_wr;
	vid_map_t    vmap;
	logic [15:0] vram_inc;
	logic        vid_en;
	logic        vid_we;
	logic        spr_en;
	logic        spr_we;
	logic [7:0]  vid_rdata;
	logic [7:0]  spr_rdata;
	logic [7:0]  vid_byte;
	logic [14:0] temp_lo;

	assign acc       = start && !busy;
	assign busy      = pend_s1;
	assign cfg_ready = 1'b1;
	assign is_rd     = acc && (operation == OP_READ);
	assign is_wr     = acc && (operation == OP_WRITE);
	assign vmap      = vid_map(vram_addr_q[13:0], mirror_q);
	assign vram_inc  = control_q[2] ? 16'd32 : 16'd1;
	assign temp_lo   = {temp_addr_q[14:8], write_data};

	assign vid_en = (is_rd || is_wr) && (reg_index == REG_DATA) && vmap.hit;
	assign vid_we = is_wr;
	assign spr_en = (is_rd || is_wr) && (reg_index == REG_OAM_DATA);
	assign spr_we = is_wr;

	tvrp_ram #(
		.WIDTH(8),
		.DEPTH(VID_DEPTH)
	) u_vid_ram (
		.clk  (clk),
		.en   (vid_en),
		.we   (vid_we),
		.addr (vmap.idx),
		.wdata(write_data),
		.rdata(vid_rdata)
	);

	tvrp_ram #(
		.WIDTH(8),
		.DEPTH(SPRITE_MEM_BYTES)
	) u_spr_ram (
		.clk  (clk),
		.en   (spr_en),
		.we   (spr_we),
		.addr (oam_addr_q[SPR_AW-1:0]),
		.wdata(write_data),
		.rdata(spr_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			mirror_q <= cfg_data;
		end
	end

	// Accept stage: register updates and the memory access are issued here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q   <= '0;
			mask_q      <= '0;
			status_q    <= '0;
			temp_addr_q <= '0;
			vram_addr_q <= '0;
			fine_x_q    <= '0;
			toggle_q    <= 1'b0;
			oam_addr_q  <= '0;
			pend_s1     <= 1'b0;
			src_s1      <= SRC_REG;
			rd_s1       <= '0;
			nmi_s1      <= 1'b0;
			pal_s1      <= 1'b0;
			ntz_s1      <= 1'b0;
		end else begin
			pend_s1 <= acc;
			if (acc) begin
				src_s1 <= SRC_REG;
				rd_s1  <= '0;
				nmi_s1 <= 1'b0;
				pal_s1 <= vmap.pal;
				ntz_s1 <= !vmap.hit;
				case (operation)
					OP_READ: begin
						case (reg_index)
							REG_STATUS: begin
								rd_s1       <= {status_q, rbuf_q[4:0]};
								status_q[2] <= 1'b0;
								toggle_q    <= 1'b0;
							end
							REG_OAM_DATA: src_s1 <= SRC_SPR;
							REG_DATA: begin
								src_s1      <= SRC_VID;
								vram_addr_q <= vram_addr_q + vram_inc;
							end
							default: ;
						endcase
					end
					OP_WRITE: begin
						case (reg_index)
							REG_CONTROL: begin
								control_q          <= write_data;
								temp_addr_q[11:10] <= write_data[1:0];
							end
							REG_MASK: mask_q <= write_data;
							REG_OAM_ADDR: oam_addr_q <= write_data;
							REG_SCROLL: begin
								if (!toggle_q) begin
									fine_x_q         <= write_data[2:0];
									temp_addr_q[4:0] <= write_data[7:3];
								end else begin
									temp_addr_q[14:12] <= write_data[2:0];
									temp_addr_q[9:5]   <= write_data[7:3];
								end
								toggle_q <= !toggle_q;
							end
							REG_ADDR: begin
								if (!toggle_q) begin
									temp_addr_q[14:8] <= {1'b0, write_data[5:0]};
								end else begin
									temp_addr_q <= temp_lo;
									vram_addr_q <= {1'b0, temp_lo};
								end
								toggle_q <= !toggle_q;
							end
							REG_DATA: vram_addr_q <= vram_addr_q + vram_inc;
							default: ;
						endcase
					end
					OP_PEEK: begin
						case (reg_index)
							REG_CONTROL: rd_s1 <= control_q;
							REG_MASK: rd_s1 <= mask_q;
							REG_STATUS: rd_s1 <= {status_q, 5'd0};
							default: ;
						endcase
					end
					OP_VBLANK: begin
						status_q[2] <= 1'b1;
						nmi_s1      <= control_q[7];
					end
					OP_FRAME: status_q <= '0;
					default: ;
				endcase
			end
		end
	end

	// Palette bytes pass the grayscale mask; an unmapped nametable reads zero.
	always_comb begin
		vid_byte = vid_rdata;
		if (ntz_s1) begin
			vid_byte = '0;
		end else if (pal_s1) begin
			vid_byte = vid_rdata & (mask_q[0] ? 8'h30 : 8'h3F);
		end
	end

	// Result stage: memory data returns and the result beat is formed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rbuf_q  <= '0;
			done_q  <= 1'b0;
			rdata_q <= '0;
			nmi_q   <= 1'b0;
		end else begin
			done_q <= pend_s1;
			if (pend_s1) begin
				nmi_q <= nmi_s1;
				case (src_s1)
					SRC_SPR: rdata_q <= spr_rdata;
					SRC_VID: begin
						rbuf_q  <= vid_byte;
						rdata_q <= pal_s1 ? vid_byte : rbuf_q;
					end
					default: rdata_q <= rd_s1;
				endcase
			end
		end
	end

	assign done      = done_q;
	assign read_data = rdata_q;
	assign nmi_raise = nmi_q;

	// Each access occupies exactly one busy cycle.
	a_busy_one: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy) else $error("busy held longer than one cycle");

	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted access did not go busy");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done) else $error("result beat missing after busy cycle");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result beat without an access");

	a_nmi_vblank: assert property (@(posedge clk) disable iff (!arst_n)
		(done && nmi_raise) |-> status_q[2]) else $error("NMI without vblank flag");

endmodule

`default_nettype wire

// ===== dv/tb_tile_video_register_port_core.sv =====
// ----------------------------------------------------------------------------
// Tile video register port core testbench
// Drives CPU register accesses and frame events into the port, predicts each
// reply from a behavioral copy of the registers and video memories, and
// checks every reply as it comes out. Mirroring is changed between phases.
// ----------------------------------------------------------------------------
module tb_tile_video_register_port_core;
	import tvrp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam logic [1:0] MIRROR_OFF = 2'd2;
	localparam logic [1:0] MIRROR_OFF_ALT = 2'd3;

	// Copy 0 runs ahead while stimulus is built; copy 1 follows accepted beats.
	localparam int AHEAD = 0;
	localparam int LIVE = 1;

	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 125;

	typedef enum logic [1:0] {SP_PATTERN, SP_NAMETABLE, SP_PALETTE, SP_UNMAPPED} vid_space_t;

	typedef struct packed {
		logic [2:0] op;
		logic [2:0] rg;
		logic [7:0] d;
	} bus_beat_t;

	typedef struct packed {
		logic [7:0] rd;
		logic       nmi;
	} reply_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [2:0] operation = '0;
	logic [2:0] reg_index = '0;
	logic [7:0] write_data = '0;
	logic       cfg_valid = 1'b0;
	logic [1:0] cfg_data = '0;
	logic       busy;
	logic       done;
	logic [7:0] read_data;
	logic       nmi_raise;
	logic       cfg_ready;

	bus_beat_t access_q[$];
	reply_t    reply_q[$];
	int        fail_cnt = 0;
	int        reply_cnt = 0;
	int        issued = 0;
	bit        no_gaps = 1'b0;

	// Register and memory images, one set per copy.
	logic [1:0]  mir [2];
	logic [7:0]  ctl [2];
	logic [7:0]  msk [2];
	logic [2:0]  stf [2];
	logic [14:0] tmp_a [2];
	logic [15:0] v_a [2];
	logic [2:0]  fx [2];
	logic        wtog [2];
	logic [7:0]  rbuf [2];
	logic [7:0]  oam_a [2];
	logic [7:0]  oam_m [2][256];
	logic [7:0]  pat_m [2][8192];
	logic [7:0]  nt_m [2][2048];
	logic [7:0]  pal_m [2][32];

	// Entries written so far, so that stimulus never reads undefined memory.
	bit oam_seen [256];
	bit pat_seen [8192];
	bit nt_seen [2048];
	bit pal_seen [32];

	tile_video_register_port_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.reg_index  (reg_index),
		.write_data (write_data),
		.done       (done),
		.read_data  (read_data),
		.nmi_raise  (nmi_raise),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic vid_space_t space_map(input int k, input logic [15:0] va, output int idx);
		logic [13:0] a;
		logic [4:0]  p;
		a = va[13:0];
		idx = 0;
		if (a <= PATTERN_END) begin
			idx = int'(a[12:0]);
			return SP_PATTERN;
		end
		if (a <= NT_END) begin
			if (mir[k] == MIRROR_VERT) begin
				idx = int'({a[10], a[9:0]});
			end else if (mir[k] == MIRROR_HORIZ) begin
				idx = int'({a[11], a[9:0]});
			end else begin
				return SP_UNMAPPED;
			end
			return SP_NAMETABLE;
		end
		p = a[4:0];
		// The backdrop entries of the sprite palettes alias the background ones.
		if (p[4] && p[1:0] == 2'b00) begin
			p[4] = 1'b0;
		end
		idx = int'(p);
		return SP_PALETTE;
	endfunction

	function automatic logic [7:0] space_read(input int k, input logic [15:0] va);
		int         idx;
		vid_space_t sp;
		sp = space_map(k, va, idx);
		case (sp)
			SP_PATTERN: return pat_m[k][idx];
			SP_NAMETABLE: return nt_m[k][idx];
			SP_PALETTE: return pal_m[k][idx] & (msk[k][0] ? 8'h30 : 8'h3F);
			default: return 8'h00;
		endcase
	endfunction

	function automatic void space_write(input int k, input logic [15:0] va, input logic [7:0] d);
		int         idx;
		vid_space_t sp;
		sp = space_map(k, va, idx);
		case (sp)
			SP_PATTERN: begin
				pat_m[k][idx] = d;
				if (k == AHEAD) pat_seen[idx] = 1'b1;
			end
			SP_NAMETABLE: begin
				nt_m[k][idx] = d;
				if (k == AHEAD) nt_seen[idx] = 1'b1;
			end
			SP_PALETTE: begin
				pal_m[k][idx] = d;
				if (k == AHEAD) pal_seen[idx] = 1'b1;
			end
			default: ;
		endcase
	endfunction

	// One bus access or frame event applied to copy k; returns the reply.
	function automatic void port_access(input int k, input logic [2:0] op, input logic [2:0] rg,
			input logic [7:0] d, output logic [7:0] rd, output logic nmi);
		logic [15:0] step;
		step = ctl[k][2] ? 16'd32 : 16'd1;
		rd = 8'h00;
		nmi = 1'b0;
		case (op)
			OP_READ: begin
				case (rg)
					REG_STATUS: begin
						rd = {stf[k], rbuf[k][4:0]};
						stf[k][2] = 1'b0;
						wtog[k] = 1'b0;
					end
					REG_OAM_DATA: rd = oam_m[k][oam_a[k]];
					REG_DATA: begin
						rd = rbuf[k];
						rbuf[k] = space_read(k, v_a[k]);
						// Palette bytes bypass the buffer delay.
						if (v_a[k][13:0] >= PALETTE_START) rd = rbuf[k];
						v_a[k] = v_a[k] + step;
					end
					default: ;
				endcase
			end
			OP_WRITE: begin
				case (rg)
					REG_CONTROL: begin
						ctl[k] = d;
						tmp_a[k][11:10] = d[1:0];
					end
					REG_MASK: msk[k] = d;
					REG_OAM_ADDR: oam_a[k] = d;
					REG_OAM_DATA: begin
						oam_m[k][oam_a[k]] = d;
						if (k == AHEAD) oam_seen[oam_a[k]] = 1'b1;
					end
					REG_SCROLL: begin
						if (!wtog[k]) begin
							fx[k] = d[2:0];
							tmp_a[k][4:0] = d[7:3];
						end else begin
							tmp_a[k][14:12] = d[2:0];
							tmp_a[k][9:5] = d[7:3];
						end
						wtog[k] = ~wtog[k];
					end
					REG_ADDR: begin
						if (!wtog[k]) begin
							tmp_a[k] = {1'b0, d[5:0], tmp_a[k][7:0]};
						end else begin
							tmp_a[k][7:0] = d;
							v_a[k] = {1'b0, tmp_a[k]};
						end
						wtog[k] = ~wtog[k];
					end
					REG_DATA: begin
						space_write(k, v_a[k], d);
						v_a[k] = v_a[k] + step;
					end
					default: ;
				endcase
			end
			OP_PEEK: begin
				case (rg)
					REG_CONTROL: rd = ctl[k];
					REG_MASK: rd = msk[k];
					REG_STATUS: rd = {stf[k], 5'b0};
					default: ;
				endcase
			end
			OP_VBLANK: begin
				stf[k][2] = 1'b1;
				nmi = ctl[k][7];
			end
			OP_FRAME: stf[k] = 3'b000;
			default: ;
		endcase
	endfunction

	function automatic bit readable(input logic [2:0] rg);
		int         idx;
		vid_space_t sp;
		if (rg == REG_OAM_DATA) return oam_seen[oam_a[AHEAD]];
		if (rg != REG_DATA) return 1'b1;
		sp = space_map(AHEAD, v_a[AHEAD], idx);
		case (sp)
			SP_PATTERN: return pat_seen[idx];
			SP_NAMETABLE: return nt_seen[idx];
			SP_PALETTE: return pal_seen[idx];
			default: return 1'b1;
		endcase
	endfunction

	// Queues one beat. A read that would land on unwritten memory becomes a
	// write to the same register instead.
	task automatic issue(input logic [2:0] op, input logic [2:0] rg, input logic [7:0] d);
		logic [7:0] rd;
		logic       nmi;
		if (op == OP_READ && !readable(rg)) begin
			op = OP_WRITE;
			d = 8'($urandom);
		end
		port_access(AHEAD, op, rg, d, rd, nmi);
		access_q.push_back('{op, rg, d});
		issued++;
	endtask

	task automatic aim(input logic [13:0] a);
		if (wtog[AHEAD]) issue(OP_READ, REG_STATUS, 8'($urandom));
		issue(OP_WRITE, REG_ADDR, {2'($urandom), a[13:8]});
		issue(OP_WRITE, REG_ADDR, a[7:0]);
	endtask

	function automatic logic [13:0] pick_addr();
		case ($urandom_range(3))
			0: return 14'($urandom_range(32'h1FFF));
			1: return 14'($urandom_range(32'h3EFF, 32'h2000));
			2: return 14'($urandom_range(32'h3FFF, 32'h3F00));
			default: return 14'($urandom_range(32'h3FFF, 32'h3FE0));
		endcase
	endfunction

	// Mirroring only changes once every reply is back and the port is quiet.
	task automatic set_mirroring(input logic [1:0] m);
		while (access_q.size() != 0 || reply_q.size() != 0 || start) @(posedge clk);
		repeat (4) @(posedge clk);
		mir[AHEAD] = m;
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_bus
		logic [7:0] rd;
		logic       nmi;
		bus_beat_t  beat;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) mir[LIVE] = cfg_data;
			if (start && !busy) begin
				port_access(LIVE, operation, reg_index, write_data, rd, nmi);
				reply_q.push_back('{rd, nmi});
			end
			if (!start || !busy) begin
				if (access_q.size() != 0 && (no_gaps || $urandom_range(99) >= 35)) begin
					beat = access_q.pop_front();
					start <= 1'b1;
					operation <= beat.op;
					reg_index <= beat.rg;
					write_data <= beat.d;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_replies
		reply_t want;
		if (arst_n && done) begin
			reply_cnt++;
			if (reply_q.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= 10)
					$display("reply %0d arrived with nothing outstanding: data %02h nmi %0b",
						reply_cnt, read_data, nmi_raise);
			end else begin
				want = reply_q.pop_front();
				if (read_data !== want.rd || nmi_raise !== want.nmi) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("reply %0d: read_data exp %02h got %02h, nmi_raise exp %0b got %0b",
							reply_cnt, want.rd, read_data, want.nmi, nmi_raise);
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		logic [14:0] fill_spots[$];
		logic [14:0] spot;
		logic [7:0]  sprite;
		int          n;
		int          phase;
		logic [1:0]  modes [PHASES];
		modes = '{MIRROR_HORIZ, MIRROR_OFF, MIRROR_VERT, MIRROR_OFF_ALT, MIRROR_HORIZ, MIRROR_VERT};
		for (int k = 0; k < 2; k++) begin
			mir[k] = MIRROR_VERT;
			ctl[k] = '0;
			msk[k] = '0;
			stf[k] = '0;
			tmp_a[k] = '0;
			v_a[k] = '0;
			fx[k] = '0;
			wtog[k] = 1'b0;
			rbuf[k] = '0;
			oam_a[k] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		set_mirroring(MIRROR_VERT);

		// Directed: NMI, status, OAM, scroll, palette aliasing and the 14-bit wrap.
		issue(OP_WRITE, REG_CONTROL, 8'h80);
		issue(OP_VBLANK, REG_DATA, 8'hFF);
		issue(OP_PEEK, REG_STATUS, 8'h00);
		issue(OP_READ, REG_STATUS, 8'h00);
		issue(OP_FRAME, REG_STATUS, 8'hFF);
		issue(OP_WRITE, REG_MASK, 8'h01);
		issue(OP_WRITE, REG_OAM_ADDR, 8'hFF);
		issue(OP_WRITE, REG_OAM_DATA, 8'hA5);
		issue(OP_READ, REG_OAM_DATA, 8'h00);
		issue(OP_WRITE, REG_SCROLL, 8'hFF);
		issue(OP_WRITE, REG_SCROLL, 8'h00);
		issue(OP_WRITE, REG_ADDR, 8'hFF);
		issue(OP_WRITE, REG_ADDR, 8'hFF);
		issue(OP_WRITE, REG_DATA, 8'hFF);
		issue(OP_WRITE, REG_DATA, 8'h00);
		issue(OP_WRITE, REG_ADDR, 8'h3F);
		issue(OP_WRITE, REG_ADDR, 8'h10);
		issue(OP_WRITE, REG_DATA, 8'h3C);
		issue(OP_WRITE, REG_ADDR, 8'h3F);
		issue(OP_WRITE, REG_ADDR, 8'hFF);
		issue(OP_READ, REG_DATA, 8'h00);
		issue(OP_READ, REG_DATA, 8'h00);
		issue(OP_UNUSED, REG_DATA, 8'hFF);
		issue(OP_WRITE, REG_STATUS, 8'h55);
		issue(OP_READ, REG_CONTROL, 8'h00);
		issue(OP_PEEK, REG_DATA, 8'h00);

		for (phase = 0; phase < PHASES; phase++) begin
			set_mirroring(modes[phase]);
			no_gaps = (phase == 2);
			n = issued + PHASE_ITEMS;
			while (issued < n) begin
				case ($urandom_range(99)) inside
					[0:34]: begin
						// Fill a run of video memory from a fresh address.
						if ($urandom_range(2) == 0) issue(OP_WRITE, REG_CONTROL, 8'($urandom));
						spot = {ctl[AHEAD][2], pick_addr()};
						aim(spot[13:0]);
						repeat ($urandom_range(8, 1)) issue(OP_WRITE, REG_DATA, 8'($urandom));
						fill_spots.push_back(spot);
						if (fill_spots.size() > 8) void'(fill_spots.pop_front());
					end
					[35:64]: begin
						// Read back a run filled earlier, with the same stride.
						if (fill_spots.size() != 0) begin
							spot = fill_spots[$urandom_range(fill_spots.size() - 1)];
							if (ctl[AHEAD][2] != spot[14])
								issue(OP_WRITE, REG_CONTROL,
									{5'($urandom), spot[14], 2'($urandom)});
							aim(spot[13:0]);
							repeat ($urandom_range(9, 1)) issue(OP_READ, REG_DATA, 8'($urandom));
						end
					end
					[65:74]: begin
						sprite = 8'($urandom);
						issue(OP_WRITE, REG_OAM_ADDR, sprite);
						if ($urandom_range(2) != 0) issue(OP_WRITE, REG_OAM_DATA, 8'($urandom));
						issue(OP_READ, REG_OAM_DATA, 8'($urandom));
					end
					[75:84]: begin
						repeat ($urandom_range(4, 1)) begin
							case ($urandom_range(5))
								0: issue(OP_VBLANK, 3'($urandom), 8'($urandom));
								1: issue(OP_PEEK, REG_STATUS, 8'($urandom));
								2: issue(OP_READ, REG_STATUS, 8'($urandom));
								3: issue(OP_FRAME, 3'($urandom), 8'($urandom));
								4: issue(OP_WRITE, REG_CONTROL, 8'($urandom));
								default: issue(OP_WRITE, REG_MASK, 8'($urandom));
							endcase
						end
					end
					[85:89]: begin
						issue(OP_WRITE, REG_SCROLL, 8'($urandom));
						if ($urandom_range(3) == 0) issue(OP_READ, REG_STATUS, 8'($urandom));
						issue(OP_WRITE, REG_SCROLL, 8'($urandom));
						issue(OP_PEEK, 3'($urandom), 8'($urandom));
					end
					default: issue(3'($urandom), 3'($urandom), 8'($urandom));
				endcase
			end
		end

		while (access_q.size() != 0 || reply_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		if (fail_cnt == 0 && reply_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
